[hw/rtl/ebk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebk_pkg
// Shared types and constants for the exchange sort by key block.
// ----------------------------------------------------------------------------
package ebk_pkg;

  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned KeyW            = 32;
  localparam int unsigned TagW            = 16;
  localparam int unsigned ModeW           = 2;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned QueuePtrW       = $clog2(QueueDepth);
  localparam int unsigned QueueCntW       = $clog2(QueueDepth + 1);

  typedef enum logic [ModeW-1:0] {
    ModeKeep = 2'd0,
    ModeAsc  = 2'd1,
    ModeDesc = 2'd2
  } order_mode_e;

  typedef enum logic [2:0] {
    BkLoad,
    BkRdI,
    BkLdI,
    BkCmp,
    BkWrI,
    BkEmitRd,
    BkEmitLd
  } back_state_e;

  // One classified record handed from the front to the back
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
    logic                   last;
    logic                   store;
    logic                   ovf;
  } ebk_entry_t;

endpackage

[hw/rtl/ebk_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebk_fifo
// Short queue of classified records between the front and the back.
// ----------------------------------------------------------------------------
module ebk_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ebk_pkg::ebk_entry_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output ebk_pkg::ebk_entry_t rdata_o,
  output logic               empty_o
);
  import ebk_pkg::*;

  ebk_entry_t           slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[hw/rtl/ebk_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebk_front
// Accepts records, counts them per set and marks those beyond capacity.
// ----------------------------------------------------------------------------
module ebk_front #(
  parameter int unsigned CAPACITY = ebk_pkg::CapacityDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic signed [ebk_pkg::KeyW-1:0]  sort_key_i,
  input  logic [ebk_pkg::TagW-1:0]         record_tag_i,
  input  logic                             last_record_i,
  output logic                             q_push_o,
  output ebk_pkg::ebk_entry_t              q_wdata_o,
  input  logic                             q_full_i
);
  import ebk_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            accept, store;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign store  = (cnt_q < CntW'(CAPACITY));

  // Dropped records that do not end a set only leave their mark in ovf
  assign q_push_o        = accept && (store || last_record_i);
  assign q_wdata_o.key   = sort_key_i;
  assign q_wdata_o.tag   = record_tag_i;
  assign q_wdata_o.last  = last_record_i;
  assign q_wdata_o.store = store;
  assign q_wdata_o.ovf   = ovf_q || !store;

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (last_record_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (store) begin
        cnt_d = cnt_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

[hw/rtl/ebk_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebk_back
// Stores a set of records, runs the exchange sort over the record memory when
// the mode asks for one, and emits the set through an output register.
// ----------------------------------------------------------------------------
module ebk_back #(
  parameter int unsigned CAPACITY = ebk_pkg::CapacityDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [ebk_pkg::ModeW-1:0]        mode_i,
  input  ebk_pkg::ebk_entry_t              q_rdata_i,
  input  logic                             q_empty_i,
  output logic                             q_pop_o,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [ebk_pkg::KeyW-1:0]  out_key_o,
  output logic [ebk_pkg::TagW-1:0]         out_tag_o,
  output logic                             out_last_o,
  output logic                             dropped_any_o
);
  import ebk_pkg::*;

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  back_state_e            state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [ModeW-1:0]       mode_q, mode_d;
  logic [AddrW-1:0]       i_q, i_d;
  logic [AddrW-1:0]       j_q, j_d;
  logic signed [KeyW-1:0] cur_key_q, cur_key_d;
  logic [TagW-1:0]        cur_tag_q, cur_tag_d;

  // Record memory, one write and one registered read port
  logic signed [KeyW-1:0] mem_key [CAPACITY];
  logic [TagW-1:0]        mem_tag [CAPACITY];
  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr, mem_raddr;
  logic signed [KeyW-1:0] mem_wkey, rd_key_q;
  logic [TagW-1:0]        mem_wtag, rd_tag_q;

  logic                   out_valid_q, out_valid_d, out_load;
  logic                   out_last_d;

  logic                   in_fire, sort_go, swap, more_j, more_i, slot_free, emit_end;

  assign in_fire   = (state_q == BkLoad) && !q_empty_i;
  assign sort_go   = ((mode_d == ModeAsc) || (mode_d == ModeDesc)) && (cnt_d >= CntW'(2));
  assign swap      = (mode_q == ModeAsc)  ? (cur_key_q > rd_key_q) :
                     (mode_q == ModeDesc) ? (rd_key_q > cur_key_q) : 1'b0;
  assign more_j    = ((CntW'(j_q) + CntW'(1)) < cnt_q);
  assign more_i    = ((CntW'(i_q) + CntW'(2)) < cnt_q);
  assign slot_free = !out_valid_q || pop;
  assign emit_end  = ((CntW'(i_q) + CntW'(1)) == cnt_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkLoad: begin
        if (in_fire && q_rdata_i.last) begin
          state_d = sort_go ? BkRdI : BkEmitRd;
        end
      end
      BkRdI:    state_d = BkLdI;
      BkLdI:    state_d = BkCmp;
      BkCmp: begin
        if (!more_j) begin
          state_d = BkWrI;
        end
      end
      BkWrI:    state_d = more_i ? BkLdI : BkEmitRd;
      BkEmitRd: begin
        if (slot_free) begin
          state_d = BkEmitLd;
        end
      end
      BkEmitLd: state_d = emit_end ? BkLoad : BkEmitRd;
      default:  state_d = BkLoad;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = i_q;
    mem_wkey   = cur_key_q;
    mem_wtag   = cur_tag_q;
    mem_raddr  = i_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    mode_d     = mode_q;
    i_d        = i_q;
    j_d        = j_q;
    cur_key_d  = cur_key_q;
    cur_tag_d  = cur_tag_q;
    out_load   = 1'b0;
    out_last_d = emit_end;
    unique case (state_q)
      BkLoad: begin
        q_pop_o = in_fire;
        if (in_fire) begin
          if (q_rdata_i.store) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_q[AddrW-1:0];
            mem_wkey  = q_rdata_i.key;
            mem_wtag  = q_rdata_i.tag;
            cnt_d     = cnt_q + CntW'(1);
          end
          if (q_rdata_i.last) begin
            ovf_d  = q_rdata_i.ovf;
            mode_d = mode_i;
            i_d    = '0;
          end
        end
      end
      BkRdI: begin
        j_d = i_q + AddrW'(1);
      end
      BkLdI: begin
        cur_key_d = rd_key_q;
        cur_tag_d = rd_tag_q;
        mem_raddr = j_q;
      end
      BkCmp: begin
        if (swap) begin
          mem_we    = 1'b1;
          mem_waddr = j_q;
          cur_key_d = rd_key_q;
          cur_tag_d = rd_tag_q;
        end
        mem_raddr = j_q + AddrW'(1);
        if (more_j) begin
          j_d = j_q + AddrW'(1);
        end
      end
      BkWrI: begin
        // Write back the winner of row i, fetch the head of row i+1
        mem_we    = 1'b1;
        mem_raddr = i_q + AddrW'(1);
        if (more_i) begin
          i_d = i_q + AddrW'(1);
          j_d = i_q + AddrW'(2);
        end else begin
          i_d = '0;
        end
      end
      BkEmitRd: begin
        mem_raddr = i_q;
      end
      BkEmitLd: begin
        out_load = 1'b1;
        i_d      = i_q + AddrW'(1);
        if (emit_end) begin
          cnt_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkLoad;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      mode_q      <= ModeAsc;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      mode_q      <= mode_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_key_q <= cur_key_d;
    cur_tag_q <= cur_tag_d;
    if (out_load) begin
      out_key_o     <= rd_key_q;
      out_tag_o     <= rd_tag_q;
      out_last_o    <= out_last_d;
      dropped_any_o <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_key[mem_waddr] <= mem_wkey;
      mem_tag[mem_waddr] <= mem_wtag;
    end
    rd_key_q <= mem_key[mem_raddr];
    rd_tag_q <= mem_tag[mem_raddr];
  end

  assign empty = !out_valid_q;

endmodule

[hw/rtl/exchange_sort_by_key_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exchange_sort_by_key_top
// Collects a set of keyed records, sorts them by key with an exchange sort when
// the order mode asks for one, and returns the set's stored records in the resulting order.
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------------
//  records   | push / full         | sort_key_i, record_tag_i, last_record_i
//  results   | empty / pop         | out_key_o, out_tag_o, out_last_o,
//            |                     | dropped_any_o
//  config    | cfg_we_i            | cfg_wdata_i (order_mode)
//
//  Records enter one per cycle while the queue is not full, through a four-entry
//  queue into the record memory. A set is sorted with one compare per cycle on the
//  single read port of the record memory; each row also loads and stores its head.
//  Each result then passes through a memory read and an output register load.
//  Reset clears control state and sets order_mode to ascending; the memory is not
//  cleared. full rises while the queue is full; a stalled pop holds the result.
// ----------------------------------------------------------------------------
module exchange_sort_by_key_top #(
  parameter int unsigned CAPACITY = ebk_pkg::CapacityDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic signed [ebk_pkg::KeyW-1:0]  sort_key_i,
  input  logic [ebk_pkg::TagW-1:0]         record_tag_i,
  input  logic                             last_record_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [ebk_pkg::KeyW-1:0]  out_key_o,
  output logic [ebk_pkg::TagW-1:0]         out_tag_o,
  output logic                             out_last_o,
  output logic                             dropped_any_o,
  input  logic                             cfg_we_i,
  input  logic [ebk_pkg::ModeW-1:0]        cfg_wdata_i
);
  import ebk_pkg::*;

  logic [ModeW-1:0] mode_q;
  logic             q_push, q_full, q_pop, q_empty;
  ebk_entry_t       q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeAsc;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  ebk_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .sort_key_i   (sort_key_i),
    .record_tag_i (record_tag_i),
    .last_record_i(last_record_i),
    .q_push_o     (q_push),
    .q_wdata_o    (q_wdata),
    .q_full_i     (q_full)
  );

  ebk_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  ebk_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .q_rdata_i    (q_rdata),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_key_o    (out_key_o),
    .out_tag_o    (out_tag_o),
    .out_last_o   (out_last_o),
    .dropped_any_o(dropped_any_o)
  );

endmodule

[hw/rtl/ebk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebk_checker
// Port-level checks on the exchange sort by key block.
// ----------------------------------------------------------------------------
module ebk_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             push,
  input logic                             full,
  input logic                             last_record_i,
  input logic                             empty,
  input logic                             pop,
  input logic signed [ebk_pkg::KeyW-1:0]  out_key_o,
  input logic [ebk_pkg::TagW-1:0]         out_tag_o,
  input logic                             out_last_o,
  input logic                             dropped_any_o
);
  import ebk_pkg::*;

  logic seen_last_q;
  logic mid_set_q;
  logic drop_q;

  // Track whether a set was closed, and the drop flag of the set in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_last_q <= 1'b0;
      mid_set_q   <= 1'b0;
      drop_q      <= 1'b0;
    end else begin
      if (push && !full && last_record_i) begin
        seen_last_q <= 1'b1;
      end
      if (pop && !empty) begin
        mid_set_q <= !out_last_o;
        drop_q    <= dropped_any_o;
      end
    end
  end

  a_no_result_before_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> seen_last_q)
    else $error("result shown before any set was closed");

  a_gap_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty) |=> empty)
    else $error("next result shown in the cycle after a pop");

  a_drop_flag_per_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && mid_set_q) |-> (dropped_any_o == drop_q))
    else $error("drop flag changed within one set");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_key_o) && $stable(out_tag_o)
                          && $stable(out_last_o)))
    else $error("stalled result changed");

endmodule

bind exchange_sort_by_key_top ebk_checker u_ebk_checker (.*);

[tb/exchange_sort_by_key_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exchange_sort_by_key_top_tb
// Self-checking bench for the keyed exchange sorter. Record sets are pushed
// through the input queue. A behavioral sort predicts every emitted record,
// its last flag and the overflow flag, and each popped record is compared
// against it. A short table of directed rows comes first, then random sets
// (small, full, overflowing) under random order modes. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module exchange_sort_by_key_top_tb;
  import ebk_pkg::*;

  localparam int unsigned Capacity    = CapacityDefault;
  localparam int unsigned RandomItems = 440;
  localparam int unsigned QuietCycles = 20;
  localparam int unsigned DrainCycles = 100;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam logic signed [KeyW-1:0] KeyMax = 32'sh7fff_ffff;
  localparam logic signed [KeyW-1:0] KeyMin = 32'sh8000_0000;

  typedef enum logic {RowRecord, RowMode} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [ModeW-1:0]       mode;
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
    bit                     last;
    bit                     typed;
    logic signed [KeyW-1:0] exp_key;
    logic [TagW-1:0]        exp_tag;
  } row_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
    logic                   last;
    logic                   dropped;
  } sorted_rec_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  logic signed [KeyW-1:0] sort_key_i;
  logic [TagW-1:0]        record_tag_i;
  logic                   last_record_i;
  logic                   empty;
  logic                   pop;
  logic signed [KeyW-1:0] out_key_o;
  logic [TagW-1:0]        out_tag_o;
  logic                   out_last_o;
  logic                   dropped_any_o;
  logic                   cfg_we_i;
  logic [ModeW-1:0]       cfg_wdata_i;

  // Predicted sorter state
  logic signed [KeyW-1:0] held_key [Capacity];
  logic [TagW-1:0]        held_tag [Capacity];
  int unsigned            held_count;
  bit                     held_dropped;
  logic [ModeW-1:0]       cur_mode;

  sorted_rec_t sorted_q[$];
  row_t        dir_rows[$];
  int unsigned fail_count;
  int unsigned send_steady;
  int unsigned pop_stall;
  int unsigned pop_steady;

  exchange_sort_by_key_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .sort_key_i   (sort_key_i),
    .record_tag_i (record_tag_i),
    .last_record_i(last_record_i),
    .empty        (empty),
    .pop          (pop),
    .out_key_o    (out_key_o),
    .out_tag_o    (out_tag_o),
    .out_last_o   (out_last_o),
    .dropped_any_o(dropped_any_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Store one record; on the last mark sort the set and, unless quiet, queue its results
  task automatic predict_record(input logic signed [KeyW-1:0] key, input logic [TagW-1:0] tag,
                                input bit last, input bit quiet);
    logic signed [KeyW-1:0] k;
    logic [TagW-1:0]        t;
    bit                     do_swap;
    if (held_count < Capacity) begin
      held_key[held_count] = key;
      held_tag[held_count] = tag;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!last) return;
    for (int i = 0; i + 1 < held_count; i++) begin
      for (int j = i + 1; j < held_count; j++) begin
        if (cur_mode == ModeAsc) do_swap = held_key[i] > held_key[j];
        else if (cur_mode == ModeDesc) do_swap = held_key[j] > held_key[i];
        else do_swap = 1'b0;
        if (do_swap) begin
          k = held_key[i];
          t = held_tag[i];
          held_key[i] = held_key[j];
          held_tag[i] = held_tag[j];
          held_key[j] = k;
          held_tag[j] = t;
        end
      end
    end
    if (!quiet) begin
      for (int n = 0; n < held_count; n++) begin
        sorted_q.push_back(sorted_rec_t'{held_key[n], held_tag[n], n + 1 == held_count,
                                         held_dropped});
      end
    end
    held_count   = 0;
    held_dropped = 1'b0;
  endtask

  function automatic int unsigned next_send_gap();
    int unsigned r;
    if (send_steady != 0) begin
      send_steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) send_steady = $urandom_range(10, 60);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit next_pop();
    int unsigned r;
    if (pop_steady != 0) begin
      pop_steady--;
      return 1'b1;
    end
    if (pop_stall != 0) begin
      pop_stall--;
      return 1'b0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) pop_steady = $urandom_range(50, 200);
    else if (r < 25) pop_stall = $urandom_range(1, 3);
    else if (r < 29) pop_stall = $urandom_range(20, 60);
    return 1'b1;
  endfunction

  function automatic logic signed [KeyW-1:0] rand_key();
    int unsigned pick;
    int          near;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom;
    if (pick < 8) begin
      // crowd keys together so equal keys show up often
      near = int'($urandom_range(0, 8)) - 4;
      return near;
    end
    case ($urandom_range(0, 3))
      0:       return KeyMax;
      1:       return KeyMin;
      2:       return '1;
      default: return '0;
    endcase
  endfunction

  function automatic row_t rec_row(input logic signed [KeyW-1:0] key, input logic [TagW-1:0] tag,
                                   input bit last, input bit typed = 1'b0,
                                   input logic signed [KeyW-1:0] exp_key = '0,
                                   input logic [TagW-1:0] exp_tag = '0);
    row_t row;
    row.kind    = RowRecord;
    row.mode    = ModeKeep;
    row.key     = key;
    row.tag     = tag;
    row.last    = last;
    row.typed   = typed;
    row.exp_key = exp_key;
    row.exp_tag = exp_tag;
    return row;
  endfunction

  function automatic row_t mode_row(input logic [ModeW-1:0] m);
    row_t row;
    row      = rec_row('0, '0, 1'b0);
    row.kind = RowMode;
    row.mode = m;
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_record(input logic signed [KeyW-1:0] key, input logic [TagW-1:0] tag,
                             input bit last, input bit typed = 1'b0,
                             input logic signed [KeyW-1:0] exp_key = '0,
                             input logic [TagW-1:0] exp_tag = '0);
    int unsigned gap;
    gap = next_send_gap();
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push          = 1'b1;
    sort_key_i    = key;
    record_tag_i  = tag;
    last_record_i = last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_record(key, tag, last, typed);
    if (typed) sorted_q.push_back(sorted_rec_t'{exp_key, exp_tag, 1'b1, 1'b0});
    @(negedge clk_i);
  endtask

  // Hold off until every result is out and the input queue has drained
  task automatic write_mode(input logic [ModeW-1:0] m);
    push = 1'b0;
    while (sorted_q.size() != 0) @(negedge clk_i);
    repeat (QuietCycles) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = m;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cur_mode = m;
  endtask

  // Result side: decide pop at the falling edge, check at the rising edge
  initial begin
    sorted_rec_t want;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      pop = next_pop();
      @(posedge clk_i);
      if (pop && !empty) begin
        if (sorted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result key %0d tag %0h", out_key_o, out_tag_o));
        end else begin
          want = sorted_q.pop_front();
          if (out_key_o !== want.key)
            report_mismatch($sformatf("out_key %0d, expected %0d", out_key_o, want.key));
          if (out_tag_o !== want.tag)
            report_mismatch($sformatf("out_tag %0h, expected %0h", out_tag_o, want.tag));
          if (out_last_o !== want.last)
            report_mismatch($sformatf("out_last %b, expected %b", out_last_o, want.last));
          if (dropped_any_o !== want.dropped)
            report_mismatch($sformatf("dropped_any %b, expected %b", dropped_any_o,
                                      want.dropped));
        end
      end
    end
  end

  initial begin
    int unsigned items_sent;
    int unsigned set_no;
    int unsigned set_len;
    int unsigned mid_at;
    rst_ni        = 1'b0;
    push          = 1'b0;
    sort_key_i    = '0;
    record_tag_i  = '0;
    last_record_i = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    fail_count    = 0;
    send_steady   = 0;
    pop_stall     = 0;
    pop_steady    = 0;
    held_count    = 0;
    held_dropped  = 1'b0;
    cur_mode      = ModeAsc;

    // single-record sets right after reset, then sets under every mode
    dir_rows.push_back(rec_row(KeyMax, 16'hffff, 1'b1, 1'b1, KeyMax, 16'hffff));
    dir_rows.push_back(rec_row(KeyMin, 16'h0000, 1'b1, 1'b1, KeyMin, 16'h0000));
    dir_rows.push_back(rec_row(0, 16'h0001, 1'b1, 1'b1, 0, 16'h0001));
    dir_rows.push_back(rec_row(-1, 16'h8000, 1'b1, 1'b1, -1, 16'h8000));
    dir_rows.push_back(rec_row(5, 16'h0001, 1'b0));
    dir_rows.push_back(rec_row(-3, 16'h0002, 1'b0));
    dir_rows.push_back(rec_row(KeyMax, 16'h0003, 1'b0));
    dir_rows.push_back(rec_row(-3, 16'h0004, 1'b0));
    dir_rows.push_back(rec_row(KeyMin, 16'h0005, 1'b1));
    dir_rows.push_back(mode_row(ModeDesc));
    dir_rows.push_back(rec_row(-1, 16'h0010, 1'b0));
    dir_rows.push_back(rec_row(KeyMax, 16'h0011, 1'b0));
    dir_rows.push_back(rec_row(1, 16'h0012, 1'b0));
    dir_rows.push_back(rec_row(KeyMax, 16'h0013, 1'b1));
    dir_rows.push_back(mode_row(ModeKeep));
    dir_rows.push_back(rec_row(3, 16'h0020, 1'b0));
    dir_rows.push_back(rec_row(1, 16'h0021, 1'b0));
    dir_rows.push_back(rec_row(2, 16'h0022, 1'b1));
    dir_rows.push_back(mode_row(ModeUnused));
    dir_rows.push_back(rec_row(9, 16'h0030, 1'b0));
    dir_rows.push_back(rec_row(-9, 16'h0031, 1'b1));
    // mode changes between records of one set: the sort takes the later one
    dir_rows.push_back(mode_row(ModeAsc));
    dir_rows.push_back(rec_row(4, 16'h0040, 1'b0));
    dir_rows.push_back(rec_row(-4, 16'h0041, 1'b0));
    dir_rows.push_back(mode_row(ModeDesc));
    dir_rows.push_back(rec_row(0, 16'h0042, 1'b1));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowMode) write_mode(dir_rows[r].mode);
      else send_record(dir_rows[r].key, dir_rows[r].tag, dir_rows[r].last, dir_rows[r].typed,
                       dir_rows[r].exp_key, dir_rows[r].exp_tag);
    end

    items_sent = 0;
    set_no     = 0;
    while (items_sent < RandomItems) begin
      if ($urandom_range(0, 3) == 0) write_mode(ModeW'($urandom_range(0, 3)));
      // a full set, one just over capacity and one well over it
      case (set_no)
        2:       set_len = Capacity;
        6:       set_len = Capacity + 1;
        11:      set_len = Capacity + 7;
        default: set_len = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 8);
      endcase
      mid_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, set_len) : set_len;
      for (int k = 0; k < set_len; k++) begin
        if (k == mid_at) write_mode(ModeW'($urandom_range(0, 3)));
        send_record(rand_key(), TagW'($urandom_range(0, 16'hffff)), k + 1 == set_len);
      end
      items_sent += set_len;
      set_no++;
    end

    push = 1'b0;
    while (sorted_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
